FILE: sv/lsge_pkg.sv
`default_nettype none
package lsge_pkg;

   localparam int NODES_DEFAULT = 32;
   localparam int NODE_W        = 6;    // node fields: six bits, node numbers 0 to 63
   localparam int STAMP_W       = 16;
   localparam int WINDOW_RESET  = 3;
   localparam int MAX_RESET     = 10;
   localparam int FULL_PERIOD   = 30;
   localparam int FULL_START    = 20;
   localparam int MAX_ENTRIES   = 32;

   // request op codes
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_RX_BEGIN  = 3'd1;
   localparam logic [2:0] OP_RX_ENTRY  = 3'd2;
   localparam logic [2:0] OP_RX_END    = 3'd3;
   localparam logic [2:0] OP_SEND      = 3'd4;

   // received array kinds
   localparam logic [7:0] MSG_FULL     = 8'd1;
   localparam logic [7:0] MSG_UPDATE   = 8'd2;

   // emitted array kinds and item kinds
   localparam logic [1:0] ARR_FULL     = 2'd1;
   localparam logic [1:0] ARR_DELTA    = 2'd2;
   localparam logic       ITEM_HEADER  = 1'b0;
   localparam logic       ITEM_ENTRY   = 1'b1;

   // configuration register indexes
   localparam logic CSR_NODE_INDEX  = 1'b0;
   localparam logic CSR_LIVE_WINDOW = 1'b1;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_BEGIN,
      CMD_ENTRY,
      CMD_END,
      CMD_SEND
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [NODE_W-1:0]    sender;
      logic [NODE_W-1:0]    node;
      logic [STAMP_W-1:0]   stamp;
      logic                 flag;   // begin: update array; entry: merge into table
   } cmd_type;

endpackage
`default_nettype wire

FILE: sv/lsge_if.sv
`default_nettype none
interface lsge_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [4:0]  sender;
   logic [15:0] main_stamp;
   logic [7:0]  msg_kind;
   logic [7:0]  entry_node;
   logic [7:0]  entry_offset;

   modport source (output valid, op, sender, main_stamp, msg_kind, entry_node, entry_offset,
                   input ready);
   modport sink   (input valid, op, sender, main_stamp, msg_kind, entry_node, entry_offset,
                   output ready);
endinterface

interface lsge_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [15:0] out_stamp;
   logic [1:0]  out_kind;
   logic [5:0]  entry_count;
   logic [4:0]  out_node;
   logic [7:0]  out_offset;
   logic        last;

   modport source (output valid, item_kind, out_stamp, out_kind, entry_count, out_node,
                   out_offset, last, input ready);
   modport sink   (input valid, item_kind, out_stamp, out_kind, entry_count, out_node,
                   out_offset, last, output ready);
endinterface
`default_nettype wire

FILE: sv/lsge_ram.sv
`default_nettype none
module lsge_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/lsge_front.sv
`default_nettype none
module lsge_front #(
   parameter int NODES = lsge_pkg::NODES_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            clearing,
   lsge_req_if.sink             req,
   output logic                 cmd_valid,
   input  wire logic            cmd_ready,
   output lsge_pkg::cmd_type    cmd
);

   logic [4:0]  rx_sender_ff, rx_sender_in;
   logic [15:0] rx_stamp_ff,  rx_stamp_in;
   logic [7:0]  rx_kind_ff,   rx_kind_in;
   logic        accept;
   logic        need;
   logic        rx_ok;

   assign req.ready = cmd_ready && !clearing;
   assign accept    = req.valid && req.ready;
   assign cmd_valid = accept && need;
   assign rx_ok     = {2'b00, rx_sender_ff} < 7'(NODES);

   always_comb begin
      rx_sender_in = rx_sender_ff;
      rx_stamp_in  = rx_stamp_ff;
      rx_kind_in   = rx_kind_ff;
      need         = 1'b0;
      cmd.kind     = lsge_pkg::CMD_TICK;
      cmd.sender   = lsge_pkg::NODE_W'(rx_sender_ff);
      cmd.node     = lsge_pkg::NODE_W'(req.entry_node[5:0]);
      cmd.stamp    = 16'(rx_stamp_ff - {8'd0, req.entry_offset});
      cmd.flag     = 1'b0;
      case (req.op)
         lsge_pkg::OP_TICK: begin
            need = 1'b1;
         end
         lsge_pkg::OP_RX_BEGIN: begin
            if (accept) begin
               rx_sender_in = req.sender;
               rx_stamp_in  = req.main_stamp;
               rx_kind_in   = req.msg_kind;
            end
            need       = {2'b00, req.sender} < 7'(NODES);
            cmd.kind   = lsge_pkg::CMD_BEGIN;
            cmd.sender = lsge_pkg::NODE_W'(req.sender);
            cmd.stamp  = req.main_stamp;
            cmd.flag   = req.msg_kind == lsge_pkg::MSG_UPDATE;
         end
         lsge_pkg::OP_RX_ENTRY: begin
            need     = rx_ok && (req.entry_node < 8'(NODES))
                       && (rx_kind_ff == lsge_pkg::MSG_FULL
                           || rx_kind_ff == lsge_pkg::MSG_UPDATE);
            cmd.kind = lsge_pkg::CMD_ENTRY;
            cmd.flag = rx_kind_ff == lsge_pkg::MSG_FULL;
         end
         lsge_pkg::OP_RX_END: begin
            need     = rx_ok && rx_kind_ff == lsge_pkg::MSG_UPDATE;
            cmd.kind = lsge_pkg::CMD_END;
         end
         lsge_pkg::OP_SEND: begin
            need     = 1'b1;
            cmd.kind = lsge_pkg::CMD_SEND;
         end
         default: begin
            need = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_sender_ff <= '0;
         rx_stamp_ff  <= '0;
         rx_kind_ff   <= '0;
      end else begin
         rx_sender_ff <= rx_sender_in;
         rx_stamp_ff  <= rx_stamp_in;
         rx_kind_ff   <= rx_kind_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lsge_queue.sv
`default_nettype none
module lsge_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire lsge_pkg::cmd_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output lsge_pkg::cmd_type      pop_data
);

   lsge_pkg::cmd_type entry_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_data   = entry_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= !wp_ff;
         if (do_pop)  rp_ff <= !rp_ff;
         cnt_ff <= 2'(cnt_ff + {1'b0, do_push} - {1'b0, do_pop});
      end
   end

endmodule
`default_nettype wire

FILE: sv/lsge_back.sv
`default_nettype none
module lsge_back #(
   parameter int NODES = lsge_pkg::NODES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [4:0]        node_index,
   input  wire logic [15:0]       live_window,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire lsge_pkg::cmd_type cmd,
   output logic                   clearing,
   lsge_rsp_if.source             rsp
);

   localparam int LW    = $clog2(NODES);
   localparam int HD    = NODES * NODES;
   localparam int HW    = $clog2(HD);
   localparam int CW    = $clog2(NODES + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MERGE, S_REF, S_RD, S_EV, S_HEAD
   } state_type;

   typedef enum logic [1:0] {W_UPD, W_END, W_COUNT, W_EMIT} mode_type;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [HW-1:0] clr_ff, clr_in;
   logic [LW-1:0] row_ff, row_in;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [15:0] stamp_ff, stamp_in;
   logic        upd_ff, upd_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  emit_ff, emit_in;
   logic        full_ff, full_in;
   logic [15:0] ref_ff, ref_in;
   logic [15:0] max_ff, max_in;
   logic [15:0] turn_ff, turn_in;
   logic [4:0]  phase_ff, phase_in;

   logic        out_v_ff, out_v_in;
   logic        kind_ff, kind_in;
   logic [15:0] ostamp_ff, ostamp_in;
   logic [1:0]  okind_ff, okind_in;
   logic [5:0]  ocount_ff, ocount_in;
   logic [4:0]  onode_ff, onode_in;
   logic [7:0]  ooff_ff, ooff_in;
   logic        last_ff, last_in;

   logic          lat_we, lat_re, his_we, his_re;
   logic [LW-1:0] lat_wa, lat_ra;
   logic [HW-1:0] his_wa, his_ra;
   logic [15:0]   lat_wd, his_wd, lat_rd, his_rd;

   logic          own_ok, out_free, take, alive_now;
   logic [LW-1:0] own, idx_l;
   logic [15:0]   h_own, turn_inc;

   function automatic logic [HW-1:0] haddr(input logic [LW-1:0] r, input logic [LW-1:0] c);
      return HW'(HW'(r) * HW'(NODES) + HW'(c));
   endfunction

   function automatic logic alive(input logic [15:0] st, input logic [15:0] refv,
                                  input logic [15:0] win);
      return ({1'b0, st} + {1'b0, win}) > {1'b0, refv};
   endfunction

   lsge_ram #(.WIDTH(16), .DEPTH(NODES)) u_latest (
      .clock(clock), .wr_en(lat_we), .wr_addr(lat_wa), .wr_data(lat_wd),
      .rd_en(lat_re), .rd_addr(lat_ra), .rd_data(lat_rd)
   );

   lsge_ram #(.WIDTH(16), .DEPTH(HD)) u_history (
      .clock(clock), .wr_en(his_we), .wr_addr(his_wa), .wr_data(his_wd),
      .rd_en(his_re), .rd_addr(his_ra), .rd_data(his_rd)
   );

   assign own_ok    = {2'b00, node_index} < 7'(NODES);
   assign own       = LW'(node_index);
   assign idx_l     = idx_ff[LW-1:0];
   assign out_free  = !out_v_ff || rsp.ready;
   assign clearing  = state_ff == S_CLEAR;
   assign cmd_ready = state_ff == S_IDLE;
   assign turn_inc  = 16'(turn_ff + 16'd1);
   assign h_own     = own_ok ? his_rd : 16'd0;
   assign alive_now = alive(lat_rd, max_ff, live_window);
   assign take      = full_ff ? alive_now
                    : (alive(h_own, ref_ff, live_window) ? (lat_rd != max_ff) : alive_now);

   assign rsp.valid       = out_v_ff;
   assign rsp.item_kind   = kind_ff;
   assign rsp.out_stamp   = ostamp_ff;
   assign rsp.out_kind    = okind_ff;
   assign rsp.entry_count = ocount_ff;
   assign rsp.out_node    = onode_ff;
   assign rsp.out_offset  = ooff_ff;
   assign rsp.last        = last_ff;

   always_comb begin
      state_in = state_ff;  mode_in = mode_ff;   clr_in = clr_ff;
      row_in = row_ff;      tgt_in = tgt_ff;     stamp_in = stamp_ff;
      upd_in = upd_ff;      idx_in = idx_ff;     cnt_in = cnt_ff;
      emit_in = emit_ff;    full_in = full_ff;   ref_in = ref_ff;
      max_in = max_ff;      turn_in = turn_ff;   phase_in = phase_ff;
      out_v_in = out_v_ff && !rsp.ready;
      kind_in = kind_ff;    ostamp_in = ostamp_ff; okind_in = okind_ff;
      ocount_in = ocount_ff; onode_in = onode_ff; ooff_in = ooff_ff; last_in = last_ff;
      lat_we = 1'b0; lat_wa = '0; lat_wd = '0; lat_re = 1'b0; lat_ra = '0;
      his_we = 1'b0; his_wa = '0; his_wd = '0; his_re = 1'b0; his_ra = '0;

      unique case (state_ff)
         S_CLEAR: begin
            his_we = 1'b1;
            his_wa = clr_ff;
            lat_we = clr_ff < HW'(NODES);
            lat_wa = clr_ff[LW-1:0];
            clr_in = HW'(clr_ff + 1'b1);
            if (clr_ff == HW'(HD - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               stamp_in = cmd.stamp;
               upd_in   = cmd.flag;
               row_in   = LW'(cmd.sender);
               idx_in   = '0;
               case (cmd.kind)
                  lsge_pkg::CMD_TICK: begin
                     max_in = 16'(max_ff + 16'd1);
                     lat_we = own_ok;
                     lat_wa = own;
                     lat_wd = 16'(max_ff + 16'd1);
                  end
                  lsge_pkg::CMD_BEGIN: begin
                     tgt_in = LW'(cmd.sender);
                     his_we = 1'b1;
                     his_wa = haddr(LW'(cmd.sender), LW'(cmd.sender));
                     his_wd = cmd.stamp;
                     lat_re = 1'b1;
                     lat_ra = LW'(cmd.sender);
                     state_in = S_MERGE;
                  end
                  lsge_pkg::CMD_ENTRY: begin
                     tgt_in = LW'(cmd.node);
                     upd_in = 1'b0;
                     his_we = 1'b1;
                     his_wa = haddr(LW'(cmd.sender), LW'(cmd.node));
                     his_wd = cmd.stamp;
                     lat_re = cmd.flag;
                     lat_ra = LW'(cmd.node);
                     if (cmd.flag) state_in = S_MERGE;
                  end
                  lsge_pkg::CMD_END: begin
                     mode_in  = W_END;
                     state_in = S_RD;
                  end
                  lsge_pkg::CMD_SEND: begin
                     turn_in  = turn_inc;
                     phase_in = (turn_inc == 16'd0 || phase_ff == 5'(lsge_pkg::FULL_PERIOD - 1))
                                ? 5'd0 : 5'(phase_ff + 5'd1);
                     full_in  = (turn_inc == 16'd0 || phase_ff == 5'(lsge_pkg::FULL_PERIOD - 1))
                                || turn_inc < 16'(lsge_pkg::FULL_START);
                     row_in   = own;
                     his_re   = 1'b1;
                     his_ra   = haddr(own, own);
                     state_in = S_REF;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MERGE: begin
            lat_we = stamp_ff > lat_rd;
            lat_wa = tgt_ff;
            lat_wd = stamp_ff;
            if (stamp_ff > max_ff) max_in = stamp_ff;
            mode_in  = W_UPD;
            state_in = upd_ff ? S_RD : S_IDLE;
         end
         S_REF: begin
            ref_in   = own_ok ? his_rd : 16'd0;
            cnt_in   = '0;
            mode_in  = W_COUNT;
            state_in = S_RD;
         end
         S_RD: begin
            if (idx_ff == CW'(NODES)) begin
               state_in = (mode_ff == W_COUNT) ? S_HEAD : S_IDLE;
            end else begin
               lat_re   = 1'b1;
               lat_ra   = idx_l;
               his_re   = 1'b1;
               his_ra   = haddr(row_ff, idx_l);
               state_in = S_EV;
            end
         end
         S_EV: begin
            state_in = S_RD;
            idx_in   = CW'(idx_ff + 1'b1);
            case (mode_ff)
               W_UPD: begin
                  his_we = (idx_l == row_ff) || alive(his_rd, stamp_ff, live_window);
                  his_wa = haddr(row_ff, idx_l);
                  his_wd = stamp_ff;
               end
               W_END: begin
                  lat_we = his_rd > lat_rd;
                  lat_wa = idx_l;
                  lat_wd = his_rd;
                  if (his_rd > max_ff) max_in = his_rd;
               end
               W_COUNT: begin
                  his_we = full_ff && own_ok;
                  his_wa = haddr(row_ff, idx_l);
                  his_wd = lat_rd;
                  if (take && cnt_ff < 6'(lsge_pkg::MAX_ENTRIES)) cnt_in = 6'(cnt_ff + 6'd1);
               end
               default: begin
                  if (take && emit_ff < cnt_ff) begin
                     if (out_free) begin
                        out_v_in  = 1'b1;
                        kind_in   = lsge_pkg::ITEM_ENTRY;
                        ostamp_in = '0;
                        okind_in  = '0;
                        ocount_in = '0;
                        onode_in  = 5'(idx_ff);
                        ooff_in   = 8'(max_ff - lat_rd);
                        last_in   = 6'(emit_ff + 6'd1) == cnt_ff;
                        emit_in   = 6'(emit_ff + 6'd1);
                     end else begin
                        idx_in   = idx_ff;
                        state_in = S_EV;
                     end
                  end
               end
            endcase
         end
         S_HEAD: begin
            if (out_free) begin
               out_v_in  = 1'b1;
               kind_in   = lsge_pkg::ITEM_HEADER;
               ostamp_in = max_ff;
               okind_in  = full_ff ? lsge_pkg::ARR_FULL : lsge_pkg::ARR_DELTA;
               ocount_in = cnt_ff;
               onode_in  = '0;
               ooff_in   = '0;
               last_in   = cnt_ff == 6'd0;
               idx_in    = '0;
               emit_in   = '0;
               mode_in   = W_EMIT;
               state_in  = (cnt_ff == 6'd0) ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;   row_ff <= row_in;     tgt_ff <= tgt_in;
      stamp_ff <= stamp_in; upd_ff <= upd_in;     idx_ff <= idx_in;
      cnt_ff <= cnt_in;     emit_ff <= emit_in;   full_ff <= full_in;
      ref_ff <= ref_in;     kind_ff <= kind_in;   ostamp_ff <= ostamp_in;
      okind_ff <= okind_in; ocount_ff <= ocount_in; onode_ff <= onode_in;
      ooff_ff <= ooff_in;   last_ff <= last_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         max_ff   <= 16'(lsge_pkg::MAX_RESET);
         turn_ff  <= '0;
         phase_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         max_ff   <= max_in;
         turn_ff  <= turn_in;
         phase_ff <= phase_in;
         out_v_ff <= out_v_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/liveness_stamp_gossip_engine_core.sv
`default_nettype none
// Gossip stamp engine: per-node latest stamps (RAM of NODES words) and an
// NODES x NODES history (RAM), with a running maximum and a send turn count.
// After reset the block runs a clearing pass over all NODES*NODES history
// words with req.ready low; csr writes are taken throughout. Requests
// are decoded by a front end into commands held in a two-deep queue; the back
// end executes them one at a time. The table walks read one entry of each
// RAM in S_RD and act on it in S_EV, which holds while the output stalls.
// Results leave through an output register, so a queued request can be taken
// while a result waits.
module liveness_stamp_gossip_engine_core #(
   parameter int NODES = lsge_pkg::NODES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lsge_req_if.sink         req,
   lsge_rsp_if.source       rsp,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [4:0]  node_index_ff, node_index_in;
   logic [15:0] live_window_ff, live_window_in;

   logic              push_valid, push_ready, pop_valid, pop_ready, clearing;
   lsge_pkg::cmd_type push_cmd, pop_cmd;

   // register file: node index and alive window
   always_comb begin
      node_index_in  = node_index_ff;
      live_window_in = live_window_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lsge_pkg::CSR_NODE_INDEX:  node_index_in  = csr_wdata[4:0];
            lsge_pkg::CSR_LIVE_WINDOW: live_window_in = csr_wdata;
            default:                   node_index_in  = node_index_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_index_ff  <= '0;
         live_window_ff <= 16'(lsge_pkg::WINDOW_RESET);
      end else begin
         node_index_ff  <= node_index_in;
         live_window_ff <= live_window_in;
      end
   end

   // front end: receive registers, range checks, command decode
   lsge_front #(.NODES(NODES)) u_front (
      .clock(clock), .reset(reset), .clearing(clearing), .req(req),
      .cmd_valid(push_valid), .cmd_ready(push_ready), .cmd(push_cmd)
   );

   lsge_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_cmd),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_cmd)
   );

   // back end: table walks, merges and array emission
   lsge_back #(.NODES(NODES)) u_back (
      .clock(clock), .reset(reset),
      .node_index(node_index_ff), .live_window(live_window_ff),
      .cmd_valid(pop_valid), .cmd_ready(pop_ready), .cmd(pop_cmd),
      .clearing(clearing), .rsp(rsp)
   );

endmodule
`default_nettype wire

FILE: tb/sv/tb_liveness_stamp_gossip_engine_core.sv
`default_nettype none
module tb_liveness_stamp_gossip_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES      = 32;
   localparam int DRAIN      = 400;    // covers a full table walk after the last result
   localparam int STALL_LIMIT = 20000; // clearing pass plus worst send under stalls, many times

   // one request as queued for the driver
   typedef struct {
      logic [2:0]  op;
      logic [4:0]  sender;
      logic [15:0] main_stamp;
      logic [7:0]  msg_kind;
      logic [7:0]  entry_node;
      logic [7:0]  entry_offset;
   } gossip_req_type;

   // one emitted array item
   typedef struct {
      logic        item_kind;
      logic [15:0] out_stamp;
      logic [1:0]  out_kind;
      logic [5:0]  entry_count;
      logic [4:0]  out_node;
      logic [7:0]  out_offset;
      logic        last;
   } gossip_item_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   lsge_req_if req_ch ();
   lsge_rsp_if rsp_ch ();

   liveness_stamp_gossip_engine_core #(.NODES(NODES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the stamp table, history and registers
   // ---------------------------------------------------------------------
   logic [15:0] stamp_table [NODES];
   logic [15:0] history     [NODES*NODES];
   logic [15:0] top_stamp;
   logic [15:0] turn_count;
   logic [4:0]  rx_sender;
   logic [15:0] rx_stamp;
   logic [7:0]  rx_kind;
   logic [4:0]  own_index;
   logic [15:0] window;

   gossip_item_type expected_items [$];
   gossip_req_type  pending_reqs [$];

   int unsigned n_requests, n_items, n_sends, n_full, n_errors;
   int unsigned send_idle_pct, recv_idle_pct;
   logic [15:0] stamp_hint;   // rough guess of the running maximum, for stimulus

   function automatic bit is_alive(logic [15:0] s, logic [15:0] ref_stamp);
      return ({1'b0, s} + {1'b0, window}) > {1'b0, ref_stamp};
   endfunction

   function automatic void merge_into_table(logic [15:0] s, int node);
      if (s > stamp_table[node])
         stamp_table[node] = s;
      if (s > top_stamp)
         top_stamp = s;
   endfunction

   // work out the array that one send emits and queue it
   function automatic void predict_send();
      int          picks [$];
      bit          full;
      bit          take;
      logic [15:0] own_ref;
      logic [15:0] h;
      gossip_item_type it;
      turn_count = turn_count + 16'd1;
      full = (turn_count % lsge_pkg::FULL_PERIOD) == 0 || turn_count < lsge_pkg::FULL_START;
      if (full) begin
         for (int i = 0; i < NODES; i++)
            history[own_index*NODES + i] = stamp_table[i];
         for (int i = 0; i < NODES; i++)
            if (is_alive(stamp_table[i], top_stamp) && picks.size() < lsge_pkg::MAX_ENTRIES)
               picks.push_back(i);
         n_full++;
      end else begin
         own_ref = history[own_index*NODES + own_index];
         for (int i = 0; i < NODES; i++) begin
            h = history[own_index*NODES + i];
            // alive at the last full send: send unless it equals the top stamp; otherwise only if alive now
            if (is_alive(h, own_ref))
               take = stamp_table[i] != top_stamp;
            else
               take = is_alive(stamp_table[i], top_stamp);
            if (take && picks.size() < lsge_pkg::MAX_ENTRIES)
               picks.push_back(i);
         end
      end
      it = '{lsge_pkg::ITEM_HEADER, top_stamp,
             full ? lsge_pkg::ARR_FULL : lsge_pkg::ARR_DELTA, 6'(picks.size()),
             5'd0, 8'd0, picks.size() == 0};
      expected_items.push_back(it);
      foreach (picks[k]) begin
         it = '{lsge_pkg::ITEM_ENTRY, 16'd0, 2'd0, 6'd0, 5'(picks[k]),
                8'(top_stamp - stamp_table[picks[k]]), k == picks.size() - 1};
         expected_items.push_back(it);
      end
      n_sends++;
   endfunction

   // apply one accepted request to the predictor
   function automatic void apply_request(gossip_req_type r);
      logic [15:0] s;
      logic [15:0] ref_stamp;
      int          base;
      case (r.op)
         lsge_pkg::OP_TICK: begin
            top_stamp = top_stamp + 16'd1;
            stamp_table[own_index] = top_stamp;
         end
         lsge_pkg::OP_RX_BEGIN: begin
            rx_sender = r.sender;
            rx_stamp  = r.main_stamp;
            rx_kind   = r.msg_kind;
            base = rx_sender * NODES;
            merge_into_table(rx_stamp, rx_sender);
            history[base + rx_sender] = rx_stamp;
            if (rx_kind == lsge_pkg::MSG_UPDATE) begin
               ref_stamp = history[base + rx_sender];
               for (int i = 0; i < NODES; i++)
                  if (is_alive(history[base + i], ref_stamp))
                     history[base + i] = rx_stamp;
            end
         end
         lsge_pkg::OP_RX_ENTRY: begin
            s = rx_stamp - {8'd0, r.entry_offset};
            base = rx_sender * NODES;
            // entries naming a node outside the table are dropped
            if (r.entry_node < NODES) begin
               if (rx_kind == lsge_pkg::MSG_FULL) begin
                  merge_into_table(s, r.entry_node);
                  history[base + r.entry_node] = s;
               end else if (rx_kind == lsge_pkg::MSG_UPDATE) begin
                  history[base + r.entry_node] = s;
               end
            end
         end
         lsge_pkg::OP_RX_END: begin
            if (rx_kind == lsge_pkg::MSG_UPDATE)
               for (int i = 0; i < NODES; i++)
                  merge_into_table(history[rx_sender*NODES + i], i);
         end
         lsge_pkg::OP_SEND: predict_send();
         default: ;   // unused op codes are ignored
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      gossip_req_type r;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r = '{req_ch.op, req_ch.sender, req_ch.main_stamp, req_ch.msg_kind,
                  req_ch.entry_node, req_ch.entry_offset};
            apply_request(r);
            n_requests++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.op           <= r.op;
               req_ch.sender       <= r.sender;
               req_ch.main_stamp   <= r.main_stamp;
               req_ch.msg_kind     <= r.msg_kind;
               req_ch.entry_node   <= r.entry_node;
               req_ch.entry_offset <= r.entry_offset;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      gossip_item_type e;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_items++;
            if (expected_items.size() == 0) begin
               $error("unexpected result item (kind %0d)", rsp_ch.item_kind);
               n_errors++;
            end else begin
               e = expected_items.pop_front();
               check_field("item_kind",   e.item_kind,   rsp_ch.item_kind);
               check_field("out_stamp",   e.out_stamp,   rsp_ch.out_stamp);
               check_field("out_kind",    e.out_kind,    rsp_ch.out_kind);
               check_field("entry_count", e.entry_count, rsp_ch.entry_count);
               check_field("out_node",    e.out_node,    rsp_ch.out_node);
               check_field("out_offset",  e.out_offset,  rsp_ch.out_offset);
               check_field("last",        e.last,        rsp_ch.last);
            end
         end
         rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // watchdog: cycles with no handshake on either channel
   int unsigned quiet_cycles;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_req(logic [2:0] op, logic [4:0] snd, logic [15:0] stmp,
                          logic [7:0] kind, logic [7:0] node, logic [7:0] ofs);
      pending_reqs.push_back('{op, snd, stmp, kind, node, ofs});
   endtask

   // stamp near the running maximum most of the time, so entries stay alive
   function automatic logic [15:0] near_stamp();
      logic [15:0] s;
      case ($urandom_range(9))
         0, 1:    s = 16'($urandom);
         2:       s = stamp_hint + 16'($urandom_range(1, 300));
         default: s = stamp_hint - 16'($urandom_range(0, 6)) + 16'($urandom_range(0, 3));
      endcase
      if (s > stamp_hint)
         stamp_hint = s;
      return s;
   endfunction

   // well-formed receive: begin, a few entries, end
   task automatic add_receive(output int unsigned count);
      logic [7:0]  kind;
      logic [15:0] ms;
      int          n;
      kind = ($urandom_range(9) == 0) ? 8'($urandom) :
             ($urandom_range(1) ? lsge_pkg::MSG_FULL : lsge_pkg::MSG_UPDATE);
      ms = near_stamp();
      n  = $urandom_range(0, 6);
      add_req(lsge_pkg::OP_RX_BEGIN, 5'($urandom), ms, kind, 8'($urandom), 8'($urandom));
      for (int i = 0; i < n; i++)
         add_req(lsge_pkg::OP_RX_ENTRY, 5'($urandom), 16'($urandom), 8'($urandom),
                 ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(NODES - 1)),
                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)));
      add_req(lsge_pkg::OP_RX_END, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
      count = n + 2;
   endtask

   task automatic build_random(int unsigned total);
      int unsigned made, c;
      made = 0;
      while (made < total) begin
         case ($urandom_range(99)) inside
            [0:44]: begin
               add_receive(c);
               made += c;
            end
            [45:61]: begin
               add_req(lsge_pkg::OP_TICK, 5'($urandom), 16'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
               stamp_hint++;
               made++;
            end
            [62:83]: begin
               add_req(lsge_pkg::OP_SEND, 5'($urandom), 16'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
               made++;
            end
            [84:91]: begin
               // stray entry or end outside a well-formed receive
               add_req($urandom_range(1) ? lsge_pkg::OP_RX_ENTRY : lsge_pkg::OP_RX_END,
                       5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom));
               made++;
            end
            default: begin
               add_req(3'($urandom_range(5, 7)), 5'($urandom), 16'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
               made++;
            end
         endcase
      end
   endtask

   // wait until the block has drained, then let a table walk finish
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_items.size() > 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == lsge_pkg::CSR_NODE_INDEX)
         own_index = value[4:0];
      else
         window = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   logic [4:0]  node_settings   [6] = '{5'd31, 5'd0, 5'd17, 5'd5, 5'd31, 5'd9};
   logic [15:0] window_settings [6] = '{16'd65535, 16'd0, 16'd3, 16'd40, 16'd1, 16'd65535};

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = lsge_pkg::CSR_NODE_INDEX;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = lsge_pkg::OP_TICK;
      req_ch.sender = '0;
      req_ch.main_stamp = '0;
      req_ch.msg_kind = '0;
      req_ch.entry_node = '0;
      req_ch.entry_offset = '0;
      rsp_ch.ready = 1'b0;
      foreach (stamp_table[i]) stamp_table[i] = '0;
      foreach (history[i]) history[i] = '0;
      top_stamp = 16'(lsge_pkg::MAX_RESET);
      turn_count = '0;
      rx_sender = '0;
      rx_stamp = '0;
      rx_kind = '0;
      own_index = '0;
      window = 16'(lsge_pkg::WINDOW_RESET);
      stamp_hint = 16'(lsge_pkg::MAX_RESET);
      send_idle_pct = 19;
      recv_idle_pct = 73;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: edge cases at reset settings
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd3, 8'd1);   // entry with no begin
      add_req(lsge_pkg::OP_RX_END, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);     // end with no begin
      add_req(lsge_pkg::OP_SEND, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_TICK, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_RX_BEGIN, 5'd31, 16'd12, lsge_pkg::MSG_FULL, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd31, 8'd255); // offset wraps below zero
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd255, 8'd1);  // node out of range
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd32, 8'd1);
      add_req(lsge_pkg::OP_RX_END, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_SEND, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_RX_BEGIN, 5'd7, 16'd13, lsge_pkg::MSG_UPDATE, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd2, 8'd0);
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd9, 8'd2);
      add_req(lsge_pkg::OP_RX_END, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_RX_BEGIN, 5'd3, 16'd65535, 8'd255, 8'd0, 8'd0); // header only, top
      add_req(lsge_pkg::OP_RX_ENTRY, 5'd0, 16'd0, 8'd0, 8'd4, 8'd0);
      add_req(lsge_pkg::OP_RX_END, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_TICK, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);        // maximum wraps to zero
      add_req(lsge_pkg::OP_SEND, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(3'd5, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(3'd6, 5'd31, 16'd65535, 8'd255, 8'd255, 8'd255);
      add_req(3'd7, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      add_req(lsge_pkg::OP_SEND, 5'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      stamp_hint = 16'd2;
      wait_idle();

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         write_csr(lsge_pkg::CSR_NODE_INDEX, {11'd0, node_settings[p]});
         write_csr(lsge_pkg::CSR_LIVE_WINDOW, window_settings[p]);
         case (p / 2)
            0: begin send_idle_pct = 19; recv_idle_pct = 73; end
            1: begin send_idle_pct = 73; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         build_random(66);
         wait_idle();
      end

      $display("covered %0d requests, %0d sends (%0d full), %0d result items checked",
               n_requests, n_sends, n_full, n_items);
      if (n_errors == 0 && expected_items.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: liveness_stamp_gossip_engine_core.f
sv/lsge_pkg.sv
sv/lsge_if.sv
sv/lsge_ram.sv
sv/lsge_front.sv
sv/lsge_queue.sv
sv/lsge_back.sv
sv/liveness_stamp_gossip_engine_core.sv
tb/sv/tb_liveness_stamp_gossip_engine_core.sv
